// ----- hdl/assert_macros.svh -----
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ----- hdl/peq_pkg.sv -----
package peq_pkg;

    localparam int STREAK_TRIGGER = 5;
    localparam int WINDOW_SECONDS = 7;

    // field widths
    localparam int CODE_W  = 3;
    localparam int ANGLE_W = 12;
    localparam int RATIO_W = 12;
    localparam int STAMP_W = 48;
    localparam int CONF_W  = 12;
    localparam int KIND_W  = 2;
    localparam int WIN_W   = 11;
    localparam int FPS_W   = 8;
    localparam int GAP_W   = 16;
    localparam int STRK_W  = 8;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;

    // slave tdata layout, lowest bit up
    localparam int IN_CODE_LO  = 0;
    localparam int IN_ANGLE_LO = IN_CODE_LO + CODE_W;
    localparam int IN_GOOD_LO  = IN_ANGLE_LO + ANGLE_W;
    localparam int IN_RATIO_LO = IN_GOOD_LO + 1;
    localparam int IN_DFLAG_LO = IN_RATIO_LO + RATIO_W;
    localparam int IN_STAMP_LO = IN_DFLAG_LO + 1;
    localparam int IN_CONF_LO  = IN_STAMP_LO + STAMP_W;
    localparam int IN_USED_W   = IN_CONF_LO + CONF_W;
    localparam int IN_DATA_W   = ((IN_USED_W + 7) / 8) * 8;

    // master tdata layout, lowest bit up
    localparam int OUT_STAMP_LO = 0;
    localparam int OUT_CONF_LO  = OUT_STAMP_LO + STAMP_W;
    localparam int OUT_WIN_LO   = OUT_CONF_LO + CONF_W;
    localparam int OUT_FPS_LO   = OUT_WIN_LO + WIN_W;
    localparam int OUT_USED_W   = OUT_FPS_LO + FPS_W;
    localparam int OUT_DATA_W   = ((OUT_USED_W + 7) / 8) * 8;

    // item kinds
    localparam logic OP_FRAME = 1'b0;
    localparam logic OP_CLEAR = 1'b1;

    // state codes
    localparam logic [CODE_W-1:0] ST_NONE       = 3'd0;
    localparam logic [CODE_W-1:0] ST_DROWSY     = 3'd1;
    localparam logic [CODE_W-1:0] ST_DISTRACTED = 3'd2;
    localparam logic [CODE_W-1:0] ST_ABSENT     = 3'd3;
    localparam logic [CODE_W-1:0] ST_FOCUS      = 3'd4;

    // event kinds
    localparam logic [KIND_W-1:0] EV_POSTURE = 2'd0;
    localparam logic [KIND_W-1:0] EV_DROWSY  = 2'd1;
    localparam logic [KIND_W-1:0] EV_ABSENT  = 2'd2;
    localparam logic [KIND_W-1:0] EV_FOCUS   = 2'd3;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NECK_LIMIT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_EYE_LIMIT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_FPS        = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_MIN_GAP    = 2'd3;

    // register reset values
    localparam logic signed [ANGLE_W-1:0] NECK_LIMIT_RST = 12'sd300;
    localparam logic [RATIO_W-1:0]        EYE_LIMIT_RST  = 12'd860;
    localparam logic [FPS_W-1:0]          FPS_RST        = 8'd30;
    localparam logic [GAP_W-1:0]          MIN_GAP_RST    = 16'd10000;

    localparam logic [STRK_W-1:0] STREAK_MAX = {STRK_W{1'b1}};

    function automatic logic [WIN_W-1:0] window_len(input logic [FPS_W-1:0] fps);
        window_len = WIN_W'(WINDOW_SECONDS) * WIN_W'(fps);
    endfunction

endpackage

// ----- hdl/posture_event_qualifier_top.sv -----
// Posture event qualifier.
// Slave stream: one transfer per analysed camera frame (tuser = 0) or a clear
// command (tuser = 1) that drops the cooldown and the last seen state.
// Master stream: one transfer per qualified event, after a post-roll of
// frames_per_second further frame transfers; window_frames is 7 * fps.
// Config channel: register index and data, always ready; write only while
// the block is idle.
// Throughput: one slave transfer per cycle unless the output stalls. The whole
// decision for a frame is a single pass of compares, 8-bit counters and one
// 48-bit subtract/compare (minimum gap) between the input register and the
// result register, so nothing loops back across cycles beyond the state registers.
// Path: the item is registered in the input register and its result, if any,
// is loaded into the output register once the result slot is free or draining.
// Stall: a stalled result holds in the output register; the input register
// still takes one more transfer, after which tready drops until the master
// side moves.
// Reset (synchronous, active low): config returns to 300 / 860 / 30 / 10000,
// all counters, cooldown, last state and pending event are cleared.
module posture_event_qualifier_top (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    // slave stream
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    // state_code[2:0], neck_tilt[14:3], posture_good[15], eye_ratio[27:16],
    // drowsy_flag[28], stamp_ms[76:29], confidence[88:77], zero pad to 96
    input  logic [peq_pkg::IN_DATA_W-1:0]   i_s_axis_tdata,
    // op[0]
    input  logic [0:0]                      i_s_axis_tuser,
    // master stream
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    // event_stamp_ms[47:0], event_confidence[59:48], window_frames[70:60],
    // fps_used[78:71], zero pad to 80
    output logic [peq_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    // event_kind[1:0]
    output logic [peq_pkg::KIND_W-1:0]      o_m_axis_tuser,
    // config write
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [peq_pkg::CFG_IDX_W-1:0]   i_cfg_addr,
    input  logic [peq_pkg::CFG_DATA_W-1:0]  i_cfg_data
);
    import peq_pkg::*;

    // config registers
    logic signed [ANGLE_W-1:0] r_neck_limit;
    logic [RATIO_W-1:0]        r_eye_limit;
    logic [FPS_W-1:0]          r_fps;
    logic [GAP_W-1:0]          r_min_gap;

    // input register
    logic                    r_in_valid;
    logic                    r_in_op;
    logic [IN_DATA_W-1:0]    r_in_data;

    // qualifier state
    logic [CODE_W-1:0]  r_prior, n_prior;
    logic               r_cool, n_cool;
    logic [STRK_W-1:0]  r_pstrk, n_pstrk;
    logic [STRK_W-1:0]  r_dstrk, n_dstrk;
    logic [STAMP_W-1:0] r_last, n_last;
    logic               r_pend, n_pend;
    logic [KIND_W-1:0]  r_pend_kind, n_pend_kind;
    logic [STAMP_W-1:0] r_pend_stamp, n_pend_stamp;
    logic [CONF_W-1:0]  r_pend_conf, n_pend_conf;
    logic [FPS_W-1:0]   r_post, n_post;

    // result register
    logic                r_out_valid;
    logic [KIND_W-1:0]   r_out_kind;
    logic [STAMP_W-1:0]  r_out_stamp;
    logic [CONF_W-1:0]   r_out_conf;
    logic [WIN_W-1:0]    r_out_win;
    logic [FPS_W-1:0]    r_out_fps;

    logic                      advance;
    logic                      step;
    logic                      emit;
    logic                      arm_req;
    logic [KIND_W-1:0]         arm_kind;
    logic                      gap_ok;
    logic                      bad;
    logic                      sleepy;
    logic [STAMP_W-1:0]        diff;

    logic [CODE_W-1:0]         f_code;
    logic signed [ANGLE_W-1:0] f_angle;
    logic                      f_good;
    logic [RATIO_W-1:0]        f_ratio;
    logic                      f_dflag;
    logic [STAMP_W-1:0]        f_stamp;
    logic [CONF_W-1:0]         f_conf;

    assign f_code  = r_in_data[IN_CODE_LO  +: CODE_W];
    assign f_angle = r_in_data[IN_ANGLE_LO +: ANGLE_W];
    assign f_good  = r_in_data[IN_GOOD_LO];
    assign f_ratio = r_in_data[IN_RATIO_LO +: RATIO_W];
    assign f_dflag = r_in_data[IN_DFLAG_LO];
    assign f_stamp = r_in_data[IN_STAMP_LO +: STAMP_W];
    assign f_conf  = r_in_data[IN_CONF_LO  +: CONF_W];

    // pipeline moves whenever the result slot is free or being drained
    assign advance         = !r_out_valid || i_m_axis_tready;
    assign step            = r_in_valid && advance;
    assign o_s_axis_tready = !r_in_valid || advance;
    assign o_cfg_ready     = 1'b1;

    assign bad    = (f_angle > r_neck_limit) || !f_good;
    assign sleepy = (f_ratio < r_eye_limit) || f_dflag;

    // minimum gap: skipped with no event yet or with the stamp going back
    assign diff   = f_stamp - r_last;
    assign gap_ok = (r_last == '0) || (f_stamp < r_last) ||
                    (diff >= STAMP_W'(r_min_gap));

    always_comb begin
        n_prior      = r_prior;
        n_cool       = r_cool;
        n_pstrk      = r_pstrk;
        n_dstrk      = r_dstrk;
        n_last       = r_last;
        n_pend       = r_pend;
        n_pend_kind  = r_pend_kind;
        n_pend_stamp = r_pend_stamp;
        n_pend_conf  = r_pend_conf;
        n_post       = r_post;
        emit         = 1'b0;
        arm_req      = 1'b0;
        arm_kind     = EV_POSTURE;

        if (step) begin
            if (r_in_op == OP_CLEAR) begin
                n_cool  = 1'b0;
                n_prior = ST_NONE;
            end else begin
                // post-roll countdown of the pending event
                if (r_pend) begin
                    if (r_post <= FPS_W'(1)) begin
                        emit   = 1'b1;
                        n_pend = 1'b0;
                        n_post = '0;
                    end else begin
                        n_post = r_post - FPS_W'(1);
                    end
                end

                if (f_code != ST_NONE) begin
                    if (r_prior != f_code) begin
                        n_prior = f_code;
                        unique case (f_code)
                            ST_DROWSY: begin
                                arm_req  = 1'b1;
                                arm_kind = EV_DROWSY;
                            end
                            ST_DISTRACTED: begin
                                arm_req  = 1'b1;
                                arm_kind = EV_POSTURE;
                            end
                            ST_ABSENT: begin
                                arm_req  = 1'b1;
                                arm_kind = EV_ABSENT;
                            end
                            ST_FOCUS: begin
                                n_cool   = 1'b0;
                                arm_req  = (r_prior != ST_NONE);
                                arm_kind = EV_FOCUS;
                            end
                            default: begin
                            end
                        endcase
                    end
                end else begin
                    n_pstrk = bad ? ((r_pstrk != STREAK_MAX) ? r_pstrk + STRK_W'(1) : r_pstrk)
                                  : '0;
                    n_dstrk = sleepy ? ((r_dstrk != STREAK_MAX) ? r_dstrk + STRK_W'(1)
                                                                : r_dstrk)
                                     : '0;
                    if (r_cool) begin
                        if (n_pstrk == '0 && n_dstrk == '0) begin
                            n_cool = 1'b0;
                        end
                    end else if (n_pstrk >= STRK_W'(STREAK_TRIGGER)) begin
                        arm_req  = 1'b1;
                        arm_kind = EV_POSTURE;
                    end else if (n_dstrk >= STRK_W'(STREAK_TRIGGER)) begin
                        arm_req  = 1'b1;
                        arm_kind = EV_DROWSY;
                    end
                end

                // a new event replaces any pending one
                if (arm_req && gap_ok) begin
                    n_cool       = 1'b1;
                    n_last       = f_stamp;
                    n_pend       = 1'b1;
                    n_pend_kind  = arm_kind;
                    n_pend_stamp = f_stamp;
                    n_pend_conf  = f_conf;
                    n_post       = r_fps;
                end
            end
        end
    end

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_neck_limit <= NECK_LIMIT_RST;
            r_eye_limit  <= EYE_LIMIT_RST;
            r_fps        <= FPS_RST;
            r_min_gap    <= MIN_GAP_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_addr)
                CFG_NECK_LIMIT: r_neck_limit <= i_cfg_data[ANGLE_W-1:0];
                CFG_EYE_LIMIT:  r_eye_limit  <= i_cfg_data[RATIO_W-1:0];
                CFG_FPS:        r_fps        <= i_cfg_data[FPS_W-1:0];
                CFG_MIN_GAP:    r_min_gap    <= i_cfg_data[GAP_W-1:0];
                default: begin
                end
            endcase
        end
    end

    // input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_s_axis_tready) begin
            r_in_valid <= i_s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_s_axis_tvalid && o_s_axis_tready) begin
            r_in_op   <= i_s_axis_tuser[0];
            r_in_data <= i_s_axis_tdata;
        end
    end

    // qualifier state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prior <= ST_NONE;
            r_cool  <= 1'b0;
            r_pstrk <= '0;
            r_dstrk <= '0;
            r_last  <= '0;
            r_pend  <= 1'b0;
            r_post  <= '0;
        end else begin
            r_prior <= n_prior;
            r_cool  <= n_cool;
            r_pstrk <= n_pstrk;
            r_dstrk <= n_dstrk;
            r_last  <= n_last;
            r_pend  <= n_pend;
            r_post  <= n_post;
        end
    end

    always_ff @(posedge i_clk) begin
        r_pend_kind  <= n_pend_kind;
        r_pend_stamp <= n_pend_stamp;
        r_pend_conf  <= n_pend_conf;
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= emit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (emit) begin
            r_out_kind  <= r_pend_kind;
            r_out_stamp <= r_pend_stamp;
            r_out_conf  <= r_pend_conf;
            r_out_win   <= window_len(r_fps);
            r_out_fps   <= r_fps;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_out_kind;
    assign o_m_axis_tdata  = {(OUT_DATA_W - OUT_USED_W)'(0),
                              r_out_fps, r_out_win, r_out_conf, r_out_stamp};

endmodule

// ----- hdl/peq_checker.sv -----
`include "assert_macros.svh"

module peq_checker (
    input logic                            i_clk,
    input logic                            i_rst_n,
    input logic                            o_s_axis_tready,
    input logic                            o_m_axis_tvalid,
    input logic                            i_m_axis_tready,
    input logic [peq_pkg::OUT_DATA_W-1:0]  o_m_axis_tdata,
    input logic [peq_pkg::KIND_W-1:0]      o_m_axis_tuser
);
    import peq_pkg::*;

    logic [WIN_W-1:0]             win;
    logic [FPS_W-1:0]             fps;
    logic                         stalled;
    logic [OUT_DATA_W+KIND_W-1:0] out_word;

    assign win      = o_m_axis_tdata[OUT_WIN_LO +: WIN_W];
    assign fps      = o_m_axis_tdata[OUT_FPS_LO +: FPS_W];
    assign stalled  = o_m_axis_tvalid && !i_m_axis_tready;
    assign out_word = {o_m_axis_tuser, o_m_axis_tdata};

    // stalled result holds
    `ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, stalled, o_m_axis_tvalid && $stable(out_word))

    // window always matches the frame rate it was emitted with
    `ASSERT_IMPLIES(a_win_fps, i_clk, i_rst_n, o_m_axis_tvalid, win == window_len(fps))

    // reset empties the result register
    `ASSERT_NEXT(a_rst_clear, i_clk, 1'b1, !i_rst_n, !o_m_axis_tvalid)

    // with no result waiting, frames are never refused
    `ASSERT_IMPLIES(a_ready_free, i_clk, i_rst_n, !o_m_axis_tvalid, o_s_axis_tready)

endmodule

bind posture_event_qualifier_top peq_checker u_peq_checker (.*);
